[rtl/core/deadband_average_feed_mapper_unit_defines.svh]
// ----------------------------------------------------------------------------
// Deadband average feed mapper: shared assertion macros
// Concurrent checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DEADBAND_AVERAGE_FEED_MAPPER_UNIT_DEFINES_SVH
`define DEADBAND_AVERAGE_FEED_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DBAFM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dbafm same-cycle check failed");

// Next-cycle implication.
`define DBAFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dbafm next-cycle check failed");

`endif

[rtl/core/dbafm_pkg.sv]
// ----------------------------------------------------------------------------
// dbafm_pkg
// Types and fixed constants of the deadband average feed mapper.
// ----------------------------------------------------------------------------
package dbafm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int FIELD_W  = 16;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
  localparam int DEADBAND  = 4;
  localparam int MAP_SHIFT = 10;
  localparam int SPAN_W    = FIELD_W + 1;
  localparam int MAP_W     = SPAN_W + SAMPLE_W;

  localparam logic [FIELD_W-1:0] FEED_HI_RESET = 16'd250;
  localparam logic [FIELD_W-1:0] FEED_LO_RESET = 16'd5;

  typedef enum logic [1:0] {
    REG_FEED_HI   = 2'd0,
    REG_FEED_LO   = 2'd1,
    REG_FEED_MODE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [FIELD_W-1:0] feed_hi;
    logic [FIELD_W-1:0] feed_lo;
    logic               feed_mode_on;
  } cfg_t;

endpackage

[rtl/core/dbafm_ring_cell.sv]
// ----------------------------------------------------------------------------
// dbafm_ring_cell
// One window slot; takes its neighbor's sample (cell 0: the new sample) whenever the window shifts.
// ----------------------------------------------------------------------------
module dbafm_ring_cell
  import dbafm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [SAMPLE_W-1:0] d,
  output logic [SAMPLE_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[rtl/core/dbafm_feed_map.sv]
// ----------------------------------------------------------------------------
// dbafm_feed_map
// Sum-to-average by reciprocal multiply, linear feed mapping, result register.
// ----------------------------------------------------------------------------
`include "deadband_average_feed_mapper_unit_defines.svh"

module dbafm_feed_map
  import dbafm_pkg::*;
#(
  parameter int WINDOW = 16
)
(
  input  logic                                       clk,
  input  logic                                       rst,
  input  cfg_t                                       cfg,
  input  logic                                       sum_valid,
  output logic                                       sum_stall,
  input  logic [SAMPLE_W+$clog2(WINDOW)-1:0]         sum,
  output logic                                       result_valid,
  input  logic                                       result_stall,
  output logic [SAMPLE_W-1:0]                        average_level,
  output logic [FIELD_W-1:0]                         feed_rate,
  output logic                                       feed_changed
);

  localparam int L      = $clog2(WINDOW);
  localparam int SUM_W  = SAMPLE_W + L;
  localparam int RSH    = SUM_W + L;
  localparam int PROD_W = 2 * SUM_W + 1;
  // ceil(2^RSH / WINDOW): exact floor division for any SUM_W-bit sum
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic              v3, v4, v5;
  logic              en3, en4, en5;
  logic [PROD_W-1:0] prod3;
  logic [SAMPLE_W-1:0] avg_w, avg4;
  logic [SPAN_W-1:0] span;
  logic [MAP_W-1:0]  prod4;
  logic [FIELD_W-1:0] fresh;
  logic [FIELD_W-1:0] current_feed, current_feed_next;
  logic              changed_next;
  logic              take5;

  assign en5 = !v5 || !result_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign sum_stall = !en3;
  assign take5 = en5 && v4;

  // stage 3: reciprocal product
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && sum_valid) begin
      prod3 <= PROD_W'(sum) * PROD_W'(RECIP);
    end
  end

  // stage 4: average and span product
  assign avg_w = prod3[RSH +: SAMPLE_W];

  always_comb begin
    if (cfg.feed_hi >= cfg.feed_lo) begin
      span = SPAN_W'(cfg.feed_hi) - SPAN_W'(cfg.feed_lo) + SPAN_W'(1);
    end else begin
      span = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      avg4  <= avg_w;
      prod4 <= MAP_W'(span) * MAP_W'(avg_w);
    end
  end

  // stage 5: feed compare and result register
  assign fresh = cfg.feed_hi - FIELD_W'(prod4 >> MAP_SHIFT);

  always_comb begin
    current_feed_next = current_feed;
    changed_next      = 1'b0;
    if (cfg.feed_mode_on && (fresh != current_feed)) begin
      current_feed_next = fresh;
      changed_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5           <= 1'b0;
      current_feed <= FEED_HI_RESET;
    end else begin
      if (en5) begin
        v5 <= v4;
      end
      if (take5) begin
        current_feed <= current_feed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take5) begin
      average_level <= avg4;
      feed_changed  <= changed_next;
    end
  end

  assign result_valid = v5;
  assign feed_rate    = current_feed;

  `DBAFM_ASSERT_IMP(a_mode_off, result_valid && !cfg.feed_mode_on, !feed_changed)
  `DBAFM_ASSERT_IMP(a_feed_bound, result_valid && feed_changed, feed_rate <= cfg.feed_hi)
  `DBAFM_ASSERT_NEXT(a_feed_idle, !take5, $stable(current_feed))

endmodule

[rtl/core/deadband_average_feed_mapper_unit.sv]
// ----------------------------------------------------------------------------
// deadband_average_feed_mapper_unit: one result per sample; one transfer
// per cycle sustained while result_stall is low, set by the deadband
// compare and running-sum update. Sync reset clears the window, sum and
// pipeline, and loads the feed limits 250 / 5, mode on.
// ----------------------------------------------------------------------------
`include "deadband_average_feed_mapper_unit_defines.svh"

module deadband_average_feed_mapper_unit
  import dbafm_pkg::*;
#(
  parameter int WINDOW = 16
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [FIELD_W-1:0]  sample,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [SAMPLE_W-1:0] average_level,
  output logic [FIELD_W-1:0]  feed_rate,
  output logic                feed_changed,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int L     = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + L;
  localparam int CMP_W = SUM_W + 2;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(1023 * WINDOW);
  localparam logic signed [CMP_W-1:0] DB_LO = CMP_W'(DEADBAND);
  localparam logic signed [CMP_W-1:0] DB_HI = CMP_W'(DEADBAND + 1);
  localparam logic signed [CMP_W-1:0] WIN_S = CMP_W'(WINDOW);

  cfg_t cfg;

  logic                       v1, v2;
  logic                       en1, en2;
  logic                       map_stall;
  logic [SAMPLE_W-1:0]        s_sat, s1;
  logic signed [CMP_W-1:0]    s_ext, lo_in, hi_in, lo1, hi1, sum_s;
  logic                       upd, shift;
  logic [SUM_W-1:0]           sum, sum_next;
  logic [SAMPLE_W-1:0]        ring_q [WINDOW];

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feed_hi      <= FEED_HI_RESET;
      cfg.feed_lo      <= FEED_LO_RESET;
      cfg.feed_mode_on <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FEED_HI:   cfg.feed_hi      <= pwdata[FIELD_W-1:0];
        REG_FEED_LO:   cfg.feed_lo      <= pwdata[FIELD_W-1:0];
        REG_FEED_MODE: cfg.feed_mode_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FEED_HI:   prdata = 32'(cfg.feed_hi);
      REG_FEED_LO:   prdata = 32'(cfg.feed_lo);
      REG_FEED_MODE: prdata = 32'(cfg.feed_mode_on);
      default:       prdata = '0;
    endcase
  end

  // stage 1: saturate and precompute deadband bounds scaled by the window:
  // s > avg+4  <=>  sum < (s-4)*W ;  s+4 < avg  <=>  sum >= (s+5)*W
  assign s_sat = (sample > FIELD_W'(SAMPLE_MAX)) ? SAMPLE_MAX : sample[SAMPLE_W-1:0];
  assign s_ext = signed'(CMP_W'(s_sat));
  assign lo_in = (s_ext - DB_LO) * WIN_S;
  assign hi_in = (s_ext + DB_HI) * WIN_S;

  assign en2 = !v2 || !map_stall;
  assign en1 = !v1 || en2;
  assign sample_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && sample_valid) begin
      s1  <= s_sat;
      lo1 <= lo_in;
      hi1 <= hi_in;
    end
  end

  // stage 2: deadband decision and running sum
  assign sum_s    = signed'(CMP_W'(sum));
  assign upd      = (sum_s < lo1) || (sum_s >= hi1);
  assign shift    = en2 && v1 && upd;
  assign sum_next = sum - SUM_W'(ring_q[WINDOW-1]) + SUM_W'(s1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      sum <= '0;
    end else begin
      if (en2) begin
        v2 <= v1;
      end
      if (shift) begin
        sum <= sum_next;
      end
    end
  end

  // window: newest sample enters cell 0, oldest leaves the last cell
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      dbafm_ring_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (s1),
        .q     (ring_q[i])
      );
    end else begin : g_body
      dbafm_ring_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (ring_q[i-1]),
        .q     (ring_q[i])
      );
    end
  end

  dbafm_feed_map #(
    .WINDOW (WINDOW)
  ) u_map (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .sum_valid     (v2),
    .sum_stall     (map_stall),
    .sum           (sum),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .average_level (average_level),
    .feed_rate     (feed_rate),
    .feed_changed  (feed_changed)
  );

  `DBAFM_ASSERT_IMP(a_sum_range, 1'b1, sum <= SUM_MAX)
  `DBAFM_ASSERT_NEXT(a_sum_hold, !shift, $stable(sum))
  `DBAFM_ASSERT_IMP(a_stall_full, sample_stall, v1 && v2)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: deadband average feed mapper testbench
// Drives samples and register writes through several feed settings, predicts
// each result from an internal copy of the window, sum, average and feed,
// and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb;
  import dbafm_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [FIELD_W-1:0]  feed;
    logic                changed;
  } feed_result_t;

  class feed_scoreboard;
    logic [SAMPLE_W-1:0] window_q [16];
    logic [3:0]          slot;
    int                  window_sum;
    logic [SAMPLE_W-1:0] level;
    logic [FIELD_W-1:0]  feed;
    logic [FIELD_W-1:0]  feed_hi;
    logic [FIELD_W-1:0]  feed_lo;
    logic                mode_on;
    feed_result_t        expected_q [$];
    int                  errors;

    function void clear();
      for (int i = 0; i < 16; i++) window_q[i] = '0;
      slot       = '0;
      window_sum = 0;
      level      = '0;
      feed       = FEED_HI_RESET;
      feed_hi    = FEED_HI_RESET;
      feed_lo    = FEED_LO_RESET;
      mode_on    = 1'b1;
      errors     = 0;
      expected_q.delete();
    endfunction

    function void set_reg(reg_index_t idx, logic [FIELD_W-1:0] value);
      case (idx)
        REG_FEED_HI:   feed_hi = value;
        REG_FEED_LO:   feed_lo = value;
        REG_FEED_MODE: mode_on = value[0];
        default: ;
      endcase
    endfunction

    // Accepted sample: advance the window model if it lies outside the deadband, and queue the expected result.
    function void note_sample(logic [FIELD_W-1:0] raw);
      int           s;
      int           span;
      int           mapped;
      feed_result_t want;
      s = (raw > 16'd1023) ? 1023 : int'(raw);
      if (s > int'(level) + DEADBAND || s + DEADBAND < int'(level)) begin
        slot = slot + 4'd1;
        window_sum = window_sum - int'(window_q[slot]) + s;
        window_q[slot] = s[SAMPLE_W-1:0];
        level = (window_sum / 16 > 1023) ? 10'd1023 : 10'(window_sum / 16);
      end
      want.changed = 1'b0;
      if (mode_on) begin
        span = (feed_hi >= feed_lo) ? int'(feed_hi) - int'(feed_lo) + 1 : 0;
        mapped = (int'(feed_hi) - (span * int'(level)) / 1024) & 16'hFFFF;
        if (mapped[FIELD_W-1:0] != feed) begin
          feed = mapped[FIELD_W-1:0];
          want.changed = 1'b1;
        end
      end
      want.level = level;
      want.feed  = feed;
      expected_q.push_back(want);
    endfunction

    function void check_result(feed_result_t got);
      feed_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with none expected: avg=%0d feed=%0d chg=%0b",
                   got.level, got.feed, got.changed);
        return;
      end
      want = expected_q.pop_front();
      if (got.level !== want.level || got.feed !== want.feed ||
          got.changed !== want.changed) begin
        errors++;
        if (errors <= 10)
          $display("expected avg=%0d feed=%0d chg=%0b got avg=%0d feed=%0d chg=%0b",
                   want.level, want.feed, want.changed, got.level, got.feed, got.changed);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                sample_valid;
  logic                sample_stall;
  logic [FIELD_W-1:0]  sample;
  logic                result_valid;
  logic                result_stall;
  logic [SAMPLE_W-1:0] average_level;
  logic [FIELD_W-1:0]  feed_rate;
  logic                feed_changed;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  feed_scoreboard board = new;
  bit quiet;
  bit hold_request;

  deadband_average_feed_mapper_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .average_level (average_level),
    .feed_rate     (feed_rate),
    .feed_changed  (feed_changed),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("deadband_average_feed_mapper_unit: mismatch");
    $finish;
  end

  task automatic send_sample(input logic [FIELD_W-1:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    board.note_sample(value);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [FIELD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  // Let the pipeline empty before touching the registers.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_samples(input int count);
    int                 kind;
    int                 near;
    logic [FIELD_W-1:0] value;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        value = 16'($urandom_range(0, 65535));
      end else if (kind < 6) begin
        value = 16'($urandom_range(0, 1023));
      end else if (kind < 8) begin
        near = int'(board.level) + $urandom_range(0, 16) - 8;
        value = (near < 0) ? 16'd0 : near[FIELD_W-1:0];
      end else begin
        // runs of one extreme pull the average to the rails
        value = (kind == 8) ? 16'd0 : 16'd1023;
        repeat ($urandom_range(0, 6)) send_sample(value);
      end
      send_sample(value);
    end
  endtask

  task automatic run_setting(input logic [FIELD_W-1:0] max_v, input logic [FIELD_W-1:0] min_v,
                             input logic mode_v, input int count);
    drain();
    write_reg(REG_FEED_HI, max_v);
    write_reg(REG_FEED_LO, min_v);
    write_reg(REG_FEED_MODE, {15'd0, mode_v});
    random_samples(count);
  endtask

  // Result side: checks transfers and makes its own stall pattern.
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        board.check_result('{average_level, feed_rate, feed_changed});
      if (hold_request) begin
        hold_left    = 60;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    board.clear();
    quiet        = 1'b0;
    hold_request = 1'b0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limits: rails, saturation just above 1023, deadband edges.
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd1024);
    send_sample(16'd1023);
    for (int k = 0; k < 4; k++) begin
      send_sample(16'(board.level) + 16'd4);
      send_sample(16'(board.level) - 16'd4);
      send_sample(16'(board.level) + 16'd5);
      send_sample(16'(board.level) - 16'd5);
    end
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    random_samples(110);

    // Widest span, with one long receiver hold-off to back the block up.
    drain();
    write_reg(REG_FEED_HI, 16'hFFFF);
    write_reg(REG_FEED_LO, 16'h0000);
    write_reg(REG_FEED_MODE, 16'd1);
    random_samples(40);
    hold_request = 1'b1;
    random_samples(120);

    run_setting(16'd100, 16'd40000, 1'b1, 125);     // min above max
    run_setting(16'd300, 16'd10, 1'b0, 125);        // feed held
    run_setting(16'd0, 16'd0, 1'b1, 95);
    run_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1, 125);
    quiet = 1'b1;
    run_setting(16'd1234, 16'd1234, 1'b1, 125);

    drain();
    if (board.errors == 0 && board.pending() == 0)
      $display("deadband_average_feed_mapper_unit: match");
    else
      $display("deadband_average_feed_mapper_unit: mismatch");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dbafm_pkg.sv
rtl/core/dbafm_ring_cell.sv
rtl/core/dbafm_feed_map.sv
rtl/core/deadband_average_feed_mapper_unit.sv
sim/tb.sv
